// ===== rtl/servo_command_to_pulse_mapper_top_macros.svh =====
// assertion helpers for the servo pulse mapper
`ifndef SERVO_COMMAND_TO_PULSE_MAPPER_TOP_MACROS_SVH
`define SERVO_COMMAND_TO_PULSE_MAPPER_TOP_MACROS_SVH

// same-cycle implication
`define SCPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scpm assertion failed");

// implication after a fixed number of cycles
`define SCPM_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("scpm assertion failed");

`endif

// ===== rtl/scpm_pkg.sv =====
`default_nettype none

package scpm_pkg;

   localparam int PULSE_W    = 16;
   localparam int ANGLE_W    = 12;
   localparam int QUO_W      = 16;
   localparam int N_CELLS    = QUO_W;
   localparam int LATENCY    = N_CELLS + 3;
   localparam int CSR_INDEX_W = 3;

   localparam logic [1:0] SERVO_POSITION   = 2'd0;
   localparam logic [1:0] SERVO_CONTINUOUS = 2'd1;

   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET    = 16'd1000;
   localparam logic [PULSE_W-1:0] CENTER_PULSE_RESET = 16'd1500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET    = 16'd2000;
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET    = 12'd1800;

   typedef enum logic [1:0] {
      MODE_PULSE = 2'd0,
      MODE_ANGLE = 2'd1,
      MODE_DUTY  = 2'd2,
      MODE_SPEED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DISABLED  = 2'd1,
      STATUS_BAD_TYPE  = 2'd2,
      STATUS_BAD_SCALE = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MOTOR_ENABLED = 3'd0,
      CSR_SERVO_TYPE    = 3'd1,
      CSR_MIN_PULSE     = 3'd2,
      CSR_CENTER_PULSE  = 3'd3,
      CSR_MAX_PULSE     = 3'd4,
      CSR_MAX_ANGLE     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                 enabled;
      logic [1:0]           servo_type;
      logic [PULSE_W-1:0]   min_pulse;
      logic [PULSE_W-1:0]   center_pulse;
      logic [PULSE_W-1:0]   max_pulse;
      logic [ANGLE_W-1:0]   max_angle;
   } cfg_type;

   // payload that walks down the divider chain
   typedef struct packed {
      logic [QUO_W-1:0]     rem;
      logic [QUO_W-1:0]     quo;
      logic [PULSE_W-1:0]   divisor;
      logic [PULSE_W-1:0]   base;
      logic                 neg;
      status_type           status;
   } div_type;

endpackage

`default_nettype wire

// ===== rtl/scpm_front.sv =====
`default_nettype none

module scpm_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire scpm_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   input  wire logic [1:0]           mode,
   input  wire logic [15:0]          pulse_width,
   input  wire logic signed [15:0]   angle_tenths,
   input  wire logic [15:0]          duty_value,
   input  wire logic [15:0]          duty_full_scale,
   input  wire logic signed [15:0]   speed_value,
   input  wire logic signed [15:0]   speed_full_scale,
   output logic                      out_valid,
   output scpm_pkg::div_type         out_data
);

   // decode stage
   logic [15:0]          span_mm, span_cm, span_mc;
   logic [11:0]          angle_clamped;
   logic [15:0]          duty_clamped;
   logic signed [16:0]   speed_ext, fs_ext, fs_neg, speed_lim, speed_abs;

   scpm_pkg::status_type status_in, a_status_ff;
   logic [15:0]          span_in, a_span_ff;
   logic [15:0]          mult_in, a_mult_ff;
   logic [15:0]          divisor_in, a_divisor_ff;
   logic [15:0]          base_in, a_base_ff;
   logic                 neg_in, a_neg_ff;
   logic                 dbl_in, a_dbl_ff;
   logic [11:0]          addend_in, a_addend_ff;
   logic                 a_valid_ff;

   // multiply stage
   logic [31:0]          product, numer;
   logic                 b_valid_ff;
   scpm_pkg::div_type    b_data_in, b_data_ff;

   assign span_mm = (cfg.max_pulse > cfg.min_pulse) ? cfg.max_pulse - cfg.min_pulse : '0;
   assign span_cm = (cfg.max_pulse > cfg.center_pulse) ?
                    cfg.max_pulse - cfg.center_pulse : '0;
   assign span_mc = (cfg.center_pulse > cfg.min_pulse) ?
                    cfg.center_pulse - cfg.min_pulse : '0;

   always_comb begin
      if (angle_tenths < 0) begin
         angle_clamped = '0;
      end else if (angle_tenths[15:0] > {4'b0, cfg.max_angle}) begin
         angle_clamped = cfg.max_angle;
      end else begin
         angle_clamped = angle_tenths[11:0];
      end
   end

   assign duty_clamped = (duty_value > duty_full_scale) ? duty_full_scale : duty_value;

   assign speed_ext = {speed_value[15], speed_value};
   assign fs_ext    = {speed_full_scale[15], speed_full_scale};
   assign fs_neg    = -fs_ext;

   always_comb begin
      if (speed_ext > fs_ext) begin
         speed_lim = fs_ext;
      end else if (speed_ext < fs_neg) begin
         speed_lim = fs_neg;
      end else begin
         speed_lim = speed_ext;
      end
      speed_abs = speed_lim[16] ? -speed_lim : speed_lim;
   end

   always_comb begin
      status_in  = scpm_pkg::STATUS_OK;
      span_in    = '0;
      mult_in    = '0;
      divisor_in = 16'd1;
      base_in    = '0;
      neg_in     = 1'b0;
      dbl_in     = 1'b0;
      addend_in  = '0;
      unique case (scpm_pkg::mode_type'(mode))
         scpm_pkg::MODE_PULSE: begin
            if (!cfg.enabled) begin
               status_in = scpm_pkg::STATUS_DISABLED;
            end else begin
               base_in = pulse_width;
            end
         end
         scpm_pkg::MODE_ANGLE: begin
            if (!cfg.enabled) begin
               status_in = scpm_pkg::STATUS_DISABLED;
            end else if (cfg.servo_type != scpm_pkg::SERVO_POSITION) begin
               status_in = scpm_pkg::STATUS_BAD_TYPE;
            end else if (cfg.max_angle == '0) begin
               base_in = cfg.min_pulse;
            end else begin
               // round to nearest: (2*span*a + full) / (2*full)
               span_in    = span_mm;
               mult_in    = {4'b0, angle_clamped};
               divisor_in = {3'b0, cfg.max_angle, 1'b0};
               dbl_in     = 1'b1;
               addend_in  = cfg.max_angle;
               base_in    = cfg.min_pulse;
            end
         end
         scpm_pkg::MODE_DUTY: begin
            if (duty_full_scale == '0) begin
               status_in = scpm_pkg::STATUS_BAD_SCALE;
            end else if (!cfg.enabled) begin
               status_in = scpm_pkg::STATUS_DISABLED;
            end else begin
               span_in    = span_mm;
               mult_in    = duty_clamped;
               divisor_in = duty_full_scale;
               base_in    = cfg.min_pulse;
            end
         end
         scpm_pkg::MODE_SPEED: begin
            if (speed_full_scale[15] || speed_full_scale == '0) begin
               status_in = scpm_pkg::STATUS_BAD_SCALE;
            end else if (!cfg.enabled) begin
               status_in = scpm_pkg::STATUS_DISABLED;
            end else if (cfg.servo_type != scpm_pkg::SERVO_CONTINUOUS) begin
               status_in = scpm_pkg::STATUS_BAD_TYPE;
            end else begin
               mult_in    = speed_abs[15:0];
               divisor_in = speed_full_scale[15:0];
               base_in    = cfg.center_pulse;
               if (speed_lim[16]) begin
                  span_in = span_mc;
                  neg_in  = 1'b1;
               end else begin
                  span_in = span_cm;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_status_ff  <= status_in;
      a_span_ff    <= span_in;
      a_mult_ff    <= mult_in;
      a_divisor_ff <= divisor_in;
      a_base_ff    <= base_in;
      a_neg_ff     <= neg_in;
      a_dbl_ff     <= dbl_in;
      a_addend_ff  <= addend_in;
   end

   assign product = a_span_ff * a_mult_ff;
   assign numer   = a_dbl_ff ? {product[30:0], 1'b0} + {20'b0, a_addend_ff} : product;

   always_comb begin
      b_data_in.rem     = numer[31:16];
      b_data_in.quo     = numer[15:0];
      b_data_in.divisor = a_divisor_ff;
      b_data_in.base    = a_base_ff;
      b_data_in.neg     = a_neg_ff;
      b_data_in.status  = a_status_ff;
   end

   always_ff @(posedge clock) begin
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

// ===== rtl/scpm_div_cell.sv =====
`default_nettype none

module scpm_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire scpm_pkg::div_type   in_data,
   output logic                     out_valid,
   output scpm_pkg::div_type        out_data
);

   // one restoring step: shift in the next numerator bit, subtract if it fits
   logic [16:0]       trial, diff;
   logic              fits;
   logic              valid_ff;
   scpm_pkg::div_type data_in, data_ff;

   assign trial = {in_data.rem, in_data.quo[15]};
   assign diff  = trial - {1'b0, in_data.divisor};
   assign fits  = trial >= {1'b0, in_data.divisor};

   always_comb begin
      data_in     = in_data;
      data_in.rem = fits ? diff[15:0] : trial[15:0];
      data_in.quo = {in_data.quo[14:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/servo_command_to_pulse_mapper_top.sv =====
// Servo command to pulse mapper. A request (start while busy is low) carries a
// mode and its operands; exactly one response comes back on rsp_valid, a
// one-cycle strobe, once the request has passed the whole pipeline. busy stays low, so a
// request may be issued every cycle and responses leave in request order, one
// per cycle. There is no backpressure on the response side: the receiver must
// capture rsp_compare_value and rsp_status in the cycle rsp_valid is high.
// The pipeline is the 16-cell restoring divider chain (one quotient bit
// per cell) plus a decode stage, a multiply stage and the output register.
// Configuration writes (csr_valid, csr_ready always high) must only happen
// while no request is in flight.
`default_nettype none

`include "servo_command_to_pulse_mapper_top_macros.svh"

module servo_command_to_pulse_mapper_top (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_mode,
   input  wire logic [15:0]         req_pulse_width,
   input  wire logic signed [15:0]  req_angle_tenths,
   input  wire logic [15:0]         req_duty_value,
   input  wire logic [15:0]         req_duty_full_scale,
   input  wire logic signed [15:0]  req_speed_value,
   input  wire logic signed [15:0]  req_speed_full_scale,
   // response channel
   output logic                     rsp_valid,
   output logic [15:0]              rsp_compare_value,
   output logic [1:0]               rsp_status,
   // configuration write channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);

   // configuration registers
   logic        enabled_ff;
   logic [1:0]  servo_type_ff;
   logic [15:0] min_pulse_ff, center_pulse_ff, max_pulse_ff;
   logic [11:0] max_angle_ff;
   scpm_pkg::cfg_type cfg;

   // divider chain taps: index 0 is the front end output
   logic              chain_valid [0:scpm_pkg::N_CELLS];
   scpm_pkg::div_type chain_data  [0:scpm_pkg::N_CELLS];

   // output stage
   scpm_pkg::div_type tail;
   logic [16:0]       pulse_sum;
   logic [15:0]       pulse_clamped;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_compare_value_in, rsp_compare_value_ff;
   logic [1:0]        rsp_status_ff;

   // the pipeline never stalls, so requests are always taken
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff      <= 1'b0;
         servo_type_ff   <= scpm_pkg::SERVO_POSITION;
         min_pulse_ff    <= scpm_pkg::MIN_PULSE_RESET;
         center_pulse_ff <= scpm_pkg::CENTER_PULSE_RESET;
         max_pulse_ff    <= scpm_pkg::MAX_PULSE_RESET;
         max_angle_ff    <= scpm_pkg::MAX_ANGLE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (scpm_pkg::csr_index_type'(csr_index))
            scpm_pkg::CSR_MOTOR_ENABLED: enabled_ff      <= csr_wdata[0];
            scpm_pkg::CSR_SERVO_TYPE:    servo_type_ff   <= csr_wdata[1:0];
            scpm_pkg::CSR_MIN_PULSE:     min_pulse_ff    <= csr_wdata;
            scpm_pkg::CSR_CENTER_PULSE:  center_pulse_ff <= csr_wdata;
            scpm_pkg::CSR_MAX_PULSE:     max_pulse_ff    <= csr_wdata;
            scpm_pkg::CSR_MAX_ANGLE:     max_angle_ff    <= csr_wdata[11:0];
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   always_comb begin
      cfg.enabled      = enabled_ff;
      cfg.servo_type   = servo_type_ff;
      cfg.min_pulse    = min_pulse_ff;
      cfg.center_pulse = center_pulse_ff;
      cfg.max_pulse    = max_pulse_ff;
      cfg.max_angle    = max_angle_ff;
   end

   // decode, status checks, operand clamping and the span multiply
   scpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (start && !busy),
      .mode             (req_mode),
      .pulse_width      (req_pulse_width),
      .angle_tenths     (req_angle_tenths),
      .duty_value       (req_duty_value),
      .duty_full_scale  (req_duty_full_scale),
      .speed_value      (req_speed_value),
      .speed_full_scale (req_speed_full_scale),
      .out_valid        (chain_valid[0]),
      .out_data         (chain_data[0])
   );

   // row of divider cells, each resolving one quotient bit per cycle
   for (genvar gi = 0; gi < scpm_pkg::N_CELLS; gi++) begin : g_cell
      scpm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[gi]),
         .in_data   (chain_data[gi]),
         .out_valid (chain_valid[gi+1]),
         .out_data  (chain_data[gi+1])
      );
   end

   assign tail = chain_data[scpm_pkg::N_CELLS];

   // offset from the base pulse, then clamp into min..max (min wins)
   assign pulse_sum = tail.neg ? {1'b0, tail.base} - {1'b0, tail.quo}
                               : {1'b0, tail.base} + {1'b0, tail.quo};

   always_comb begin
      if (pulse_sum < {1'b0, min_pulse_ff}) begin
         pulse_clamped = min_pulse_ff;
      end else if (pulse_sum > {1'b0, max_pulse_ff}) begin
         pulse_clamped = max_pulse_ff;
      end else begin
         pulse_clamped = pulse_sum[15:0];
      end
      // refused requests report a zero compare value
      rsp_compare_value_in = (tail.status == scpm_pkg::STATUS_OK) ? pulse_clamped : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[scpm_pkg::N_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_compare_value_ff <= rsp_compare_value_in;
      rsp_status_ff        <= tail.status;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_compare_value_ff;
   assign rsp_status        = rsp_status_ff;

   // every request yields its response after the fixed pipeline latency
   `SCPM_ASSERT_DELAY(a_latency, clock, reset, start && !busy, scpm_pkg::LATENCY, rsp_valid)
   // no response appears without a matching request
   `SCPM_ASSERT_DELAY(a_no_spurious, clock, reset, !(start && !busy), scpm_pkg::LATENCY, !rsp_valid)
   // a refused request never carries a compare value
   `SCPM_ASSERT_IMPLY(a_refused_zero, clock, reset, rsp_valid && rsp_status != scpm_pkg::STATUS_OK, rsp_compare_value == 16'd0)

endmodule

`default_nettype wire
